FILE: design/scfr_pkg.sv
`default_nettype none

package scfr_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'hAF;

    localparam logic [7:0] MAX_FUNC_RESET = 8'd240;
    localparam logic [5:0] MAX_LEN_RESET  = 6'd49;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FUNC = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LEN  = 2'd1;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_HDR2    = 3'd1,
        PH_FUNC    = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_SUM     = 3'd5
    } phase_t;

    typedef struct packed {
        logic       frame_end;
        logic [7:0] function_code;
        logic [7:0] payload_byte;
        logic [5:0] byte_index;
        logic [5:0] payload_length;
        logic       checksum_ok;
    } result_t;

    typedef struct packed {
        logic [7:0] max_function_code;
        logic [5:0] max_payload_length;
    } limits_t;

endpackage

`default_nettype wire

FILE: design/scfr_parser.sv
`default_nettype none

module scfr_parser
    import scfr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    byte_valid,
    input  wire logic [7:0] byte_in,
    input  wire limits_t limits,
    output logic         res_valid,
    output result_t      res
);

    phase_t     phase_reg, phase_next;
    logic [5:0] remaining_reg, remaining_next;
    logic [5:0] count_reg, count_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] func_reg, func_next;
    logic [5:0] length_reg, length_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            remaining_reg <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            func_reg      <= '0;
            length_reg    <= '0;
        end
        else if (byte_valid)
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            func_reg      <= func_next;
            length_reg    <= length_next;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        func_next      = func_reg;
        length_next    = length_reg;
        res_valid      = 1'b0;
        res            = '0;
        res.function_code  = func_reg;
        res.payload_length = length_reg;

        unique case (phase_reg)
            PH_HUNT:
            begin
                if (byte_in == HDR_FIRST)
                begin
                    sum_next   = byte_in;
                    phase_next = PH_HDR2;
                end
            end
            PH_HDR2:
            begin
                if (byte_in == HDR_SECOND)
                begin
                    sum_next   = sum_reg + byte_in;
                    phase_next = PH_FUNC;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_FUNC:
            begin
                if (byte_in <= limits.max_function_code)
                begin
                    sum_next   = sum_reg + byte_in;
                    func_next  = byte_in;
                    phase_next = PH_LEN;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_LEN:
            begin
                if ((byte_in[7:6] == 2'b00) && (byte_in[5:0] <= limits.max_payload_length))
                begin
                    sum_next       = sum_reg + byte_in;
                    length_next    = byte_in[5:0];
                    remaining_next = byte_in[5:0];
                    count_next     = '0;
                    phase_next     = (byte_in[5:0] == 6'd0) ? PH_SUM : PH_PAYLOAD;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_PAYLOAD:
            begin
                if (remaining_reg == 6'd0)
                begin
                    phase_next = PH_HUNT;
                end
                else
                begin
                    sum_next         = sum_reg + byte_in;
                    res_valid        = 1'b1;
                    res.payload_byte = byte_in;
                    res.byte_index   = count_reg;
                    count_next       = count_reg + 6'd1;
                    remaining_next   = remaining_reg - 6'd1;
                    if (remaining_reg == 6'd1)
                    begin
                        phase_next = PH_SUM;
                    end
                end
            end
            PH_SUM:
            begin
                res_valid       = 1'b1;
                res.frame_end   = 1'b1;
                res.checksum_ok = (byte_in == sum_reg);
                phase_next      = PH_HUNT;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

`ifndef SYNTHESIS
    // While payload is expected there is always at least one byte left to come.
    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (remaining_reg != 6'd0))
        else $error("payload phase with no bytes remaining");

    a_count_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> ((count_reg + remaining_reg) == length_reg))
        else $error("payload count and remaining bytes disagree with length");

    a_result_phase: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((phase_reg == PH_PAYLOAD) || (phase_reg == PH_SUM)))
        else $error("result raised outside payload or checksum phase");

    // A finished frame always sends the parser back to hunting.
    a_end_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && res_valid && res.frame_end) |=> (phase_reg == PH_HUNT))
        else $error("parser did not return to hunting after frame end");
`endif

endmodule

`default_nettype wire

FILE: design/scfr_out_buf.sv
`default_nettype none

module scfr_out_buf
    import scfr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    wr_valid,
    output logic         wr_ready,
    input  wire result_t wr_data,
    output logic         rd_valid,
    input  wire logic    rd_ready,
    output result_t      rd_data
);

    result_t head_reg;
    result_t skid_reg;
    logic    head_valid_reg;
    logic    skid_valid_reg;
    logic    pop;
    logic    push;

    assign wr_ready = !skid_valid_reg;
    assign push     = wr_valid && wr_ready;
    assign pop      = head_valid_reg && rd_ready;
    assign rd_valid = head_valid_reg;
    assign rd_data  = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                head_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (head_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                head_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_reg <= skid_reg;
            end
            else if (push)
            begin
                head_reg <= wr_data;
            end
        end
        else if (push)
        begin
            if (head_valid_reg)
            begin
                skid_reg <= wr_data;
            end
            else
            begin
                head_reg <= wr_data;
            end
        end
    end

`ifndef SYNTHESIS
    // The skid entry is only ever filled behind an occupied head.
    a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid entry valid while head entry empty");
`endif

endmodule

`default_nettype wire

FILE: design/sum_checked_frame_receiver_top.sv
// Channel   Handshake              Payload
// in        in_valid / in_ready    rx_byte
// out       out_valid / out_ready  frame_end, function_code, payload_byte,
//                                  byte_index, payload_length, checksum_ok
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte is taken per clock cycle while in_ready is high; the output buffer registers its result.
// The parser state and one 8-bit add and compare form the step taken on each byte.
// A two-entry output buffer lets input continue while one result waits to be taken.
// Input stalls only when both output entries are full; cfg_ready is always high.
// Reset returns the parser to hunting and restores the default limits.
`default_nettype none

module sum_checked_frame_receiver_top
    import scfr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             rx_byte,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        frame_end,
    output logic [7:0]                  function_code,
    output logic [7:0]                  payload_byte,
    output logic [5:0]                  byte_index,
    output logic [5:0]                  payload_length,
    output logic                        checksum_ok,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]             cfg_data
);

    limits_t limits_reg, limits_next;
    logic    byte_accept;
    logic    res_valid;
    result_t res;
    result_t out_res;
    logic    buf_ready;

    assign cfg_ready   = 1'b1;
    assign in_ready    = buf_ready;
    assign byte_accept = in_valid && in_ready;

    always_comb
    begin
        limits_next = limits_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MAX_FUNC: limits_next.max_function_code  = cfg_data;
                CFG_MAX_LEN:  limits_next.max_payload_length = cfg_data[5:0];
                default:      limits_next = limits_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.max_function_code  <= MAX_FUNC_RESET;
            limits_reg.max_payload_length <= MAX_LEN_RESET;
        end
        else
        begin
            limits_reg <= limits_next;
        end
    end

    scfr_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_accept),
        .byte_in    (rx_byte),
        .limits     (limits_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    scfr_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (byte_accept && res_valid),
        .wr_ready (buf_ready),
        .wr_data  (res),
        .rd_valid (out_valid),
        .rd_ready (out_ready),
        .rd_data  (out_res)
    );

    assign frame_end      = out_res.frame_end;
    assign function_code  = out_res.function_code;
    assign payload_byte   = out_res.payload_byte;
    assign byte_index     = out_res.byte_index;
    assign payload_length = out_res.payload_length;
    assign checksum_ok    = out_res.checksum_ok;

endmodule

`default_nettype wire
